/* rtl/strq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strq_pkg
// Command and status codes of the shortest-time ready queue.
// ---------------------------------------------------------------------------
package strq_pkg;

   typedef logic [0:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_INSERT = 1'b0;
   localparam cmd_type CMD_POP    = 1'b1;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

/* rtl/strq_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strq_req_if / strq_rsp_if
// Valid/ready channels for queue requests and their results.
// ---------------------------------------------------------------------------
interface strq_req_if #(
   parameter int ID_BITS  = 16,
   parameter int KEY_BITS = 32
);
   logic                  valid;
   logic                  ready;
   strq_pkg::cmd_type     cmd;
   logic [ID_BITS-1:0]    tid;
   logic [KEY_BITS-1:0]   run_time;

   modport source (output valid, output cmd, output tid, output run_time,
                   input ready);
   modport sink   (input valid, input cmd, input tid, input run_time,
                   output ready);
endinterface

interface strq_rsp_if #(
   parameter int ID_BITS  = 16,
   parameter int KEY_BITS = 32,
   parameter int CNT_BITS = 5
);
   logic                  valid;
   logic                  ready;
   strq_pkg::status_type  status;
   logic [ID_BITS-1:0]    out_tid;
   logic [KEY_BITS-1:0]   out_run_time;
   logic [CNT_BITS-1:0]   entry_count;

   modport source (output valid, output status, output out_tid,
                   output out_run_time, output entry_count, input ready);
   modport sink   (input valid, input status, input out_tid,
                   input out_run_time, input entry_count, output ready);
endinterface

/* rtl/shortest_time_ready_queue_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shortest_time_ready_queue_core
// Sorted ready queue keyed by accumulated run time; pop returns least key.
// ---------------------------------------------------------------------------
// Entries live in one memory with one read and one write port, used as a ring
// from a head pointer, kept in ascending key order. One request is worked at
// a time and req ready is high only between requests. A pop reads the head
// entry, takes it in the pop state and then loads the result register. An
// insert walks from the tail through the memory one entry per read/compare
// pair, moving each entry whose key is greater than or equal to the new key
// up by one slot, and writes the new entry in the compare step that meets a
// smaller key or else in the put state. A dropped insert (full) or a pop on
// an empty queue goes straight to the done state. The result register lets a
// new request be accepted while the previous result still waits to be taken;
// a finished request holds in its last cycle for as long as that result is
// not taken.
// ---------------------------------------------------------------------------
module shortest_time_ready_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16,
   parameter int KEY_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   strq_req_if.sink    req_bus,
   strq_rsp_if.source  rsp_bus
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WORD_W = ID_BITS + KEY_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_PUT  = 3'd3;
   localparam logic [2:0] S_POP  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [ID_BITS-1:0]       new_id_ff, new_id_in;
   logic [KEY_BITS-1:0]      new_key_ff, new_key_in;
   strq_pkg::status_type     res_status_ff, res_status_in;
   logic [ID_BITS-1:0]       res_id_ff, res_id_in;
   logic [KEY_BITS-1:0]      res_key_ff, res_key_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   strq_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic [KEY_BITS-1:0]      rsp_key_ff, rsp_key_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic [WORD_W-1:0]        mem_ff [QUEUE_DEPTH];
   logic [WORD_W-1:0]        rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [WORD_W-1:0]        wr_data;

   logic [CNT_W-1:0]         cnt_dec;
   logic [KEY_BITS-1:0]      rd_key;
   logic                     req_fire;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W:0]   pos);
      logic [IDX_W+1:0] sum;
      sum = {2'b00, base} + {1'b0, pos};
      if (sum >= (IDX_W+2)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+2)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign req_fire              = req_bus.valid && req_bus.ready;
   assign cnt_dec               = count_ff - CNT_W'(1);
   assign rd_key                = rd_data_ff[KEY_BITS-1:0];

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.out_tid       = rsp_id_ff;
   assign rsp_bus.out_run_time  = rsp_key_ff;
   assign rsp_bus.entry_count   = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      new_id_in     = new_id_ff;
      new_key_in    = new_key_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_key_in    = res_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = phys(head_ff, {1'b0, idx_ff});
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, {1'b0, idx_ff} + (IDX_W+1)'(1));
      wr_data       = {new_id_ff, new_key_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               new_id_in     = req_bus.tid;
               new_key_in    = req_bus.run_time;
               res_status_in = strq_pkg::ST_OK;
               res_id_in     = '0;
               res_key_in    = '0;
               if (req_bus.cmd == strq_pkg::CMD_POP) begin
                  if (count_ff == '0) begin
                     res_status_in = strq_pkg::ST_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     rd_addr  = head_ff;
                     state_in = S_POP;
                  end
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  res_status_in = strq_pkg::ST_FULL;
                  state_in      = S_DONE;
               end else if (count_ff == '0) begin
                  idx_in   = '0;
                  state_in = S_PUT;
               end else begin
                  idx_in   = cnt_dec[IDX_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en = 1'b1;
            if (rd_key >= new_key_ff) begin
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  idx_in   = idx_ff - IDX_W'(1);
                  state_in = S_READ;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, {1'b0, idx_ff});
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end
         S_POP: begin
            res_id_in  = rd_data_ff[WORD_W-1:KEY_BITS];
            res_key_in = rd_key;
            head_in    = phys(head_ff, (IDX_W+1)'(1));
            count_in   = cnt_dec;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_key_in    = res_key_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      new_id_ff     <= new_id_in;
      new_key_ff    <= new_key_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

/* sim/tb_shortest_time_ready_queue_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_shortest_time_ready_queue_core
// Drives insert and pop requests into the ready queue and compares each result
// against a behavioral copy of the sorted queue, field by field, in order.
// Random fill, drain and mixed phases push the queue to full and empty, with
// gaps on the request side and stalls on the result side.
// ---------------------------------------------------------------------------
module tb_shortest_time_ready_queue_core;

   localparam int DEPTH     = 16;
   localparam int ID_W      = 16;
   localparam int KEY_W     = 32;
   localparam int CNT_W     = 5;
   localparam int N_RANDOM  = 1550;
   localparam int TAIL_WAIT = 60;

   typedef struct {
      strq_pkg::cmd_type cmd;
      logic [ID_W-1:0]   tid;
      logic [KEY_W-1:0]  run_time;
      bit                wait_for_drain;
   } queue_request_type;

   typedef struct {
      strq_pkg::status_type status;
      logic [ID_W-1:0]      tid;
      logic [KEY_W-1:0]     run_time;
      logic [CNT_W-1:0]     count;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   strq_req_if #(.ID_BITS(ID_W), .KEY_BITS(KEY_W)) req_if ();
   strq_rsp_if #(.ID_BITS(ID_W), .KEY_BITS(KEY_W), .CNT_BITS(CNT_W)) rsp_if ();

   shortest_time_ready_queue_core #(
      .QUEUE_DEPTH(DEPTH),
      .ID_BITS(ID_W),
      .KEY_BITS(KEY_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if.sink),
      .rsp_bus(rsp_if.source)
   );

   queue_request_type pending_requests[$];
   queue_result_type  expected_results[$];
   logic [KEY_W-1:0]  shadow_keys[DEPTH];
   logic [ID_W-1:0]   shadow_ids[DEPTH];
   int                shadow_count = 0;
   int                n_sent = 0;
   int                n_checked = 0;
   int                errors = 0;

   always #6 clock = ~clock;

   task automatic add_request(input strq_pkg::cmd_type cmd, input logic [ID_W-1:0] id,
                              input logic [KEY_W-1:0] key, input bit drain);
      queue_request_type r;
      r.cmd = cmd;
      r.tid = id;
      r.run_time = key;
      r.wait_for_drain = drain;
      pending_requests.push_back(r);
   endtask

   task automatic predict_queue_result(input strq_pkg::cmd_type cmd,
                                       input logic [ID_W-1:0] id,
                                       input logic [KEY_W-1:0] key);
      queue_result_type r;
      int pos;
      r.status = strq_pkg::ST_OK;
      r.tid = '0;
      r.run_time = '0;
      if (cmd == strq_pkg::CMD_INSERT) begin
         if (shadow_count >= DEPTH) begin
            r.status = strq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_keys[pos] < key) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_ids[i] = shadow_ids[i-1];
            end
            shadow_keys[pos] = key;
            shadow_ids[pos] = id;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = strq_pkg::ST_EMPTY;
         end else begin
            r.tid = shadow_ids[0];
            r.run_time = shadow_keys[0];
            for (int i = 0; i + 1 < shadow_count; i++) begin
               shadow_keys[i] = shadow_keys[i+1];
               shadow_ids[i] = shadow_ids[i+1];
            end
            shadow_count--;
         end
      end
      r.count = shadow_count[CNT_W-1:0];
      expected_results.push_back(r);
   endtask

   // request driver
   always @(posedge clock) begin
      queue_request_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_queue_result(req_if.cmd, req_if.tid, req_if.run_time);
            n_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() == 0) begin
               req_if.valid <= 1'b0;
            end else if (pending_requests[0].wait_for_drain
                         && expected_results.size() != 0) begin
               req_if.valid <= 1'b0;
            end else if (!(n_sent >= 500 && n_sent < 800)
                         && $urandom_range(0, 99) < 21) begin
               req_if.valid <= 1'b0;
            end else begin
               nxt = pending_requests.pop_front();
               req_if.cmd <= nxt.cmd;
               req_if.tid <= nxt.tid;
               req_if.run_time <= nxt.run_time;
               req_if.valid <= 1'b1;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no request outstanding: status %0d", rsp_if.status);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                  errors++;
               end
               if (rsp_if.out_tid !== want.tid) begin
                  $error("out_tid: expected %0h, actual %0h",
                         want.tid, rsp_if.out_tid);
                  errors++;
               end
               if (rsp_if.out_run_time !== want.run_time) begin
                  $error("out_run_time: expected %0h, actual %0h",
                         want.run_time, rsp_if.out_run_time);
                  errors++;
               end
               if (rsp_if.entry_count !== want.count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.count, rsp_if.entry_count);
                  errors++;
               end
            end
            n_checked++;
         end
         rsp_if.ready <= (n_checked >= 900 && n_checked < 1200)
                         || ($urandom_range(0, 99) >= 21);
      end
   end

   initial begin
      #(12ns * 1000000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int mode;
      int pop_pct;
      logic [KEY_W-1:0] key;
      req_if.valid = 1'b0;
      req_if.cmd = strq_pkg::CMD_INSERT;
      req_if.tid = '0;
      req_if.run_time = '0;
      rsp_if.ready = 1'b0;

      // empty pop, extremes, equal keys, fill to full, dropped insert
      add_request(strq_pkg::CMD_POP, 16'h1234, 32'h5678, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'h0001, 32'd7, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'h0002, 32'd7, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'h0003, 32'd7, 1'b0);
      for (int i = 0; i < 11; i++)
         add_request(strq_pkg::CMD_INSERT, ID_W'($urandom), $urandom, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'hAAAA, 32'h5555_5555, 1'b0);
      for (int i = 0; i < 4; i++)
         add_request(strq_pkg::CMD_POP, ID_W'($urandom), $urandom, 1'b0);
      add_request(strq_pkg::CMD_INSERT, 16'h0004, 32'd7, 1'b0);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 40 == 0) mode = $urandom_range(0, 2);
         pop_pct = (mode == 0) ? 20 : (mode == 1) ? 80 : 50;
         case ($urandom_range(0, 9))
            0: key = '0;
            1: key = '1;
            2, 3, 4: key = $urandom_range(0, 7);
            default: key = $urandom;
         endcase
         add_request(($urandom_range(0, 99) < pop_pct) ? strq_pkg::CMD_POP
                                                       : strq_pkg::CMD_INSERT,
                     ID_W'($urandom), key, (n == 0) || ($urandom_range(0, 199) == 0));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // hold until stimulus is gone and every result is back, then let the tail settle
      while (pending_requests.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
rtl/strq_pkg.sv
rtl/strq_if.sv
rtl/shortest_time_ready_queue_core.sv
sim/tb_shortest_time_ready_queue_core.sv
